/* rtl/mrsv_pkg.sv */
// Shared types, constants and helpers for the map record stream validator.
// No dependencies; every other file imports this package.
package mrsv_pkg;

    localparam int HEADER_BYTES = 24;
    localparam int RECORD_BYTES = 16;

    localparam int COUNT_W = 33;
    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

    // Largest cell count whose file size still fits in 32 bits.
    localparam logic [63:0] CELL_LIMIT =
        64'((64'hFFFF_FFFF - 64'(HEADER_BYTES)) / 64'(RECORD_BYTES));

    // Header byte offsets.
    localparam logic [4:0] OFS_VERSION   = 5'd4;
    localparam logic [4:0] OFS_FLAGS     = 5'd6;
    localparam logic [4:0] OFS_WIDTH     = 5'd8;
    localparam logic [4:0] OFS_HEIGHT    = 5'd12;
    localparam logic [4:0] OFS_CSIZE     = 5'd16;
    localparam logic [4:0] OFS_SKYBOX    = 5'd20;

    // Offsets of the upper byte of each 16-bit word in a cell record.
    localparam logic [3:0] CELL_FLOOR_HI = 4'd1;
    localparam logic [3:0] CELL_CEIL_HI  = 4'd3;
    localparam logic [3:0] CELL_FLAGS_HI = 4'd13;
    localparam logic [3:0] CELL_RSVD_HI  = 4'd15;

    // Status codes.
    localparam logic [2:0] ST_OK          = 3'd0;
    localparam logic [2:0] ST_BOUNDS      = 3'd1;
    localparam logic [2:0] ST_FORMAT      = 3'd2;
    localparam logic [2:0] ST_VERSION     = 3'd3;
    localparam logic [2:0] ST_UNSUPPORTED = 3'd4;
    localparam logic [2:0] ST_OVERFLOW    = 3'd5;

    // Register indexes.
    localparam logic [1:0] REG_SCHEMA_VERSION   = 2'd0;
    localparam logic [1:0] REG_KNOWN_MAP_FLAGS  = 2'd1;
    localparam logic [1:0] REG_KNOWN_CELL_FLAGS = 2'd2;

    localparam logic [15:0] SCHEMA_VERSION_RESET = 16'd1;

    typedef struct packed {
        logic [15:0] schema_version;
        logic [15:0] known_map_flags;
        logic [15:0] known_cell_flags;
    } cfg_t;

    typedef struct packed {
        logic [31:0] cells;
        logic        cells_ovf;
        logic        size_ovf;
        logic [31:0] expected;
    } size_info_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [31:0] map_width;
        logic [31:0] map_height;
        logic [15:0] map_flags;
        logic [31:0] csize;
        logic [31:0] skybox;
        logic [31:0] total_cells;
    } result_t;

    // Magic "MAP1" byte by position.
    function automatic logic [7:0] magic_byte(input logic [1:0] idx);
        logic [7:0] b;
        case (idx)
            2'd0:    b = 8'h4D;
            2'd1:    b = 8'h41;
            2'd2:    b = 8'h50;
            default: b = 8'h31;
        endcase
        return b;
    endfunction

endpackage

/* rtl/mrsv_apb_regs.sv */
// Configuration registers behind an APB-style port.
// Depends on mrsv_pkg for the register indexes and the cfg_t type.
module mrsv_apb_regs (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [3:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready,
    output mrsv_pkg::cfg_t      cfg
);
    import mrsv_pkg::*;

    cfg_t cfg_reg;
    logic wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;
    assign cfg    = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.schema_version   <= SCHEMA_VERSION_RESET;
            cfg_reg.known_map_flags  <= '0;
            cfg_reg.known_cell_flags <= '0;
        end
        else if (wr_en)
        begin
            unique case (paddr[3:2])
                REG_SCHEMA_VERSION:   cfg_reg.schema_version   <= pwdata[15:0];
                REG_KNOWN_MAP_FLAGS:  cfg_reg.known_map_flags  <= pwdata[15:0];
                REG_KNOWN_CELL_FLAGS: cfg_reg.known_cell_flags <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[3:2])
            REG_SCHEMA_VERSION:   prdata = {16'd0, cfg_reg.schema_version};
            REG_KNOWN_MAP_FLAGS:  prdata = {16'd0, cfg_reg.known_map_flags};
            REG_KNOWN_CELL_FLAGS: prdata = {16'd0, cfg_reg.known_cell_flags};
            default:              prdata = '0;
        endcase
    end

endmodule

/* rtl/mrsv_size_calc.sv */
// Two-stage pipeline that turns header width and height into the cell count,
// its overflow flags and the expected file length. Depends on mrsv_pkg.
module mrsv_size_calc (
    input  logic                  clk,
    input  logic [31:0]           header_width,
    input  logic [31:0]           header_height,
    output mrsv_pkg::size_info_t  size
);
    import mrsv_pkg::*;

    logic [63:0] prod_reg;
    size_info_t  size_reg;
    size_info_t  size_next;

    // The dimensions settle at byte 15; the result is ready well before byte 23.
    always_comb
    begin
        size_next.cells     = prod_reg[31:0];
        size_next.cells_ovf = |prod_reg[63:32];
        size_next.size_ovf  = prod_reg > CELL_LIMIT;
        size_next.expected  = 32'(HEADER_BYTES) + {prod_reg[27:0], 4'd0};
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= 64'(header_width) * 64'(header_height);
        size_reg <= size_next;
    end

    assign size = size_reg;

endmodule

/* rtl/mrsv_parser.sv */
// Stream state: header capture, cell record checks, byte counter and the
// final status. Depends on mrsv_pkg and on the size info from mrsv_size_calc.
module mrsv_parser (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  take,
    input  logic [7:0]            data_byte,
    input  logic                  last_byte,
    input  mrsv_pkg::cfg_t        cfg,
    input  mrsv_pkg::size_info_t  size,
    output logic [31:0]           header_width,
    output logic [31:0]           header_height,
    output mrsv_pkg::result_t     result
);
    import mrsv_pkg::*;

    logic [COUNT_W-1:0] byte_count_reg, byte_count_next;
    logic               magic_good_reg, magic_good_next;
    logic [15:0]        version_reg, version_next;
    logic [15:0]        flags_reg, flags_next;
    logic [31:0]        width_reg, width_next;
    logic [31:0]        height_reg, height_next;
    logic [31:0]        csize_reg, csize_next;
    logic [31:0]        skybox_reg, skybox_next;
    logic [3:0]         rec_off_reg, rec_off_next;
    logic [15:0]        floor_reg, floor_next;
    logic [7:0]         word_lo_reg, word_lo_next;
    logic [2:0]         first_err_reg, first_err_next;
    logic [2:0]         pending_reg, pending_next;

    logic [COUNT_W-1:0] n;
    logic [4:0]         hpos;
    logic [15:0]        word;
    logic [2:0]         cell_st;
    logic [2:0]         st;

    assign hpos = byte_count_reg[4:0];
    assign word = {data_byte, word_lo_reg};
    assign n    = (byte_count_reg == COUNT_MAX) ? byte_count_reg
                                                : byte_count_reg + 1'b1;

    // State with the current byte applied, before any end-of-file clear.
    always_comb
    begin
        magic_good_next = magic_good_reg;
        version_next    = version_reg;
        flags_next      = flags_reg;
        width_next      = width_reg;
        height_next     = height_reg;
        csize_next      = csize_reg;
        skybox_next     = skybox_reg;
        rec_off_next    = rec_off_reg;
        floor_next      = floor_reg;
        word_lo_next    = word_lo_reg;
        first_err_next  = first_err_reg;
        pending_next    = pending_reg;
        cell_st         = ST_OK;
        if (byte_count_reg < COUNT_W'(HEADER_BYTES))
        begin
            if (hpos < OFS_VERSION)
            begin
                if (data_byte != magic_byte(hpos[1:0]))
                    magic_good_next = 1'b0;
            end
            else if (hpos < OFS_FLAGS)
                version_next[8*hpos[0] +: 8] = data_byte;
            else if (hpos < OFS_WIDTH)
                flags_next[8*hpos[0] +: 8] = data_byte;
            else if (hpos < OFS_HEIGHT)
                width_next[8*hpos[1:0] +: 8] = data_byte;
            else if (hpos < OFS_CSIZE)
                height_next[8*hpos[1:0] +: 8] = data_byte;
            else if (hpos < OFS_SKYBOX)
                csize_next[8*hpos[1:0] +: 8] = data_byte;
            else
                skybox_next[8*hpos[1:0] +: 8] = data_byte;
        end
        else
        begin
            rec_off_next = rec_off_reg + 1'b1;
            if (!rec_off_reg[0])
                word_lo_next = data_byte;
            else
            begin
                case (rec_off_reg)
                    CELL_FLOOR_HI: floor_next = word;
                    CELL_CEIL_HI:
                        pending_next = ($signed(floor_reg) > $signed(word))
                                       ? ST_FORMAT : ST_OK;
                    CELL_FLAGS_HI:
                        if ((word & ~cfg.known_cell_flags) != 16'd0)
                            pending_next = ST_UNSUPPORTED;
                    CELL_RSVD_HI:
                    begin
                        cell_st = (word != 16'd0) ? ST_FORMAT : pending_reg;
                        if (first_err_reg == ST_OK)
                            first_err_next = cell_st;
                        pending_next = ST_OK;
                    end
                    default: ;
                endcase
            end
        end
    end

    // Final status, in the order the file format defines its checks.
    always_comb
    begin
        if (n < COUNT_W'(HEADER_BYTES))
            st = ST_BOUNDS;
        else if (!magic_good_next)
            st = ST_FORMAT;
        else if (version_next != cfg.schema_version)
            st = ST_VERSION;
        else if ((flags_next & ~cfg.known_map_flags) != 16'd0)
            st = ST_UNSUPPORTED;
        else if (csize_next == 32'd0)
            st = ST_FORMAT;
        else if (width_next == 32'd0 || height_next == 32'd0)
            st = ST_FORMAT;
        else if (size.cells_ovf || size.size_ovf)
            st = ST_OVERFLOW;
        else if (n < COUNT_W'(size.expected))
            st = ST_BOUNDS;
        else if (n > COUNT_W'(size.expected))
            st = ST_FORMAT;
        else
            st = first_err_next;

        result.status      = st;
        result.map_width   = width_next;
        result.map_height  = height_next;
        result.map_flags   = flags_next;
        result.csize       = csize_next;
        result.skybox      = skybox_next;
        result.total_cells = (st == ST_OK) ? size.cells : 32'd0;
    end

    assign byte_count_next = n;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_count_reg <= '0;
            magic_good_reg <= 1'b1;
            version_reg    <= '0;
            flags_reg      <= '0;
            width_reg      <= '0;
            height_reg     <= '0;
            csize_reg      <= '0;
            skybox_reg     <= '0;
            rec_off_reg    <= '0;
            floor_reg      <= '0;
            word_lo_reg    <= '0;
            first_err_reg  <= ST_OK;
            pending_reg    <= ST_OK;
        end
        else if (take)
        begin
            if (last_byte)
            begin
                byte_count_reg <= '0;
                magic_good_reg <= 1'b1;
                version_reg    <= '0;
                flags_reg      <= '0;
                width_reg      <= '0;
                height_reg     <= '0;
                csize_reg      <= '0;
                skybox_reg     <= '0;
                rec_off_reg    <= '0;
                floor_reg      <= '0;
                word_lo_reg    <= '0;
                first_err_reg  <= ST_OK;
                pending_reg    <= ST_OK;
            end
            else
            begin
                byte_count_reg <= byte_count_next;
                magic_good_reg <= magic_good_next;
                version_reg    <= version_next;
                flags_reg      <= flags_next;
                width_reg      <= width_next;
                height_reg     <= height_next;
                csize_reg      <= csize_next;
                skybox_reg     <= skybox_next;
                rec_off_reg    <= rec_off_next;
                floor_reg      <= floor_next;
                word_lo_reg    <= word_lo_next;
                first_err_reg  <= first_err_next;
                pending_reg    <= pending_next;
            end
        end
    end

    assign header_width  = width_reg;
    assign header_height = height_reg;

endmodule

/* rtl/map_record_stream_validator.sv */
// Map record stream validator: takes one byte per cycle, back to back.
// The result is registered and shows in the cycle after the last byte is taken.
// Throughput: one byte per cycle; only a held result stalls a last byte.
// The cell count multiply runs in a two-stage pipeline behind the header.
// Reset clears stream state and loads register defaults; no clearing pass.
module map_record_stream_validator (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        data_valid,
    output logic        data_ready,
    input  logic [7:0]  data_byte,
    input  logic        last_byte,
    output logic        result_valid,
    input  logic        result_ready,
    output logic [2:0]  status,
    output logic [31:0] map_width,
    output logic [31:0] map_height,
    output logic [15:0] map_flags,
    output logic [31:0] cell_size_out,
    output logic [31:0] skybox_out,
    output logic [31:0] total_cells
);
    import mrsv_pkg::*;

    cfg_t       cfg;
    size_info_t size;
    result_t    result;
    result_t    result_reg;
    logic       valid_reg;
    logic       take;
    logic [31:0] header_width;
    logic [31:0] header_height;

    // Only a final byte needs the result slot, so other bytes keep flowing.
    assign data_ready = result_ready || !valid_reg || !last_byte;
    assign take       = data_valid && data_ready;

    mrsv_apb_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    mrsv_size_calc u_size (
        .clk           (clk),
        .header_width  (header_width),
        .header_height (header_height),
        .size          (size)
    );

    mrsv_parser u_parser (
        .clk           (clk),
        .rst_n         (rst_n),
        .take          (take),
        .data_byte     (data_byte),
        .last_byte     (last_byte),
        .cfg           (cfg),
        .size          (size),
        .header_width  (header_width),
        .header_height (header_height),
        .result        (result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (take && last_byte)
            valid_reg <= 1'b1;
        else if (result_ready)
            valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (take && last_byte)
            result_reg <= result;
    end

    assign result_valid  = valid_reg;
    assign status        = result_reg.status;
    assign map_width     = result_reg.map_width;
    assign map_height    = result_reg.map_height;
    assign map_flags     = result_reg.map_flags;
    assign cell_size_out = result_reg.csize;
    assign skybox_out    = result_reg.skybox;
    assign total_cells   = result_reg.total_cells;

    a_last_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        (take && last_byte) |=> result_valid)
        else $error("final byte did not produce a result");

    a_ok_has_cells: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && status == ST_OK) |-> (total_cells != 32'd0))
        else $error("ok status with zero cell count");

    a_err_no_cells: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && status != ST_OK) |-> (total_cells == 32'd0))
        else $error("error status with nonzero cell count");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && !result_ready) |-> !(take && last_byte))
        else $error("held result overwritten by a new file");

endmodule

/* dv/map_result_checker.sv */
// Checker for the map record stream validator: follows register writes and
// accepted bytes, predicts the result of every map file and compares it.
// Depends on mrsv_pkg for status codes, offsets, register indexes and result_t.
module map_result_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    input  logic        pready,
    input  logic        data_valid,
    input  logic        data_ready,
    input  logic [7:0]  data_byte,
    input  logic        last_byte,
    input  logic        result_valid,
    input  logic        result_ready,
    input  logic [2:0]  status,
    input  logic [31:0] map_width,
    input  logic [31:0] map_height,
    input  logic [15:0] map_flags,
    input  logic [31:0] cell_size_out,
    input  logic [31:0] skybox_out,
    input  logic [31:0] total_cells,
    output int          errors,
    output int          outstanding,
    output int          maps_checked,
    output int          maps_ok,
    output int          bytes_seen
);
    timeunit 1ns;
    timeprecision 1ps;

    import mrsv_pkg::*;

    // "MAP1" as it arrives, lowest byte first.
    localparam logic [31:0] MAGIC_LE = 32'h3150_414D;

    logic [15:0] want_version;
    logic [15:0] map_mask;
    logic [15:0] cell_mask;

    logic [COUNT_W-1:0] nbytes;
    logic        magic_ok;
    logic [15:0] hdr_version;
    logic [15:0] hdr_flags;
    logic [31:0] hdr_width;
    logic [31:0] hdr_height;
    logic [31:0] hdr_csize;
    logic [31:0] hdr_skybox;
    logic [3:0]  cell_ofs;
    logic [7:0]  low_byte;
    logic [15:0] floor_word;
    logic [2:0]  cell_verdict;
    logic [2:0]  first_bad_cell;

    result_t expected_maps[$];
    int fault_count;
    int checked_count;
    int ok_count;
    int byte_count;

    function automatic void clear_map();
        nbytes         = '0;
        magic_ok       = 1'b1;
        hdr_version    = '0;
        hdr_flags      = '0;
        hdr_width      = '0;
        hdr_height     = '0;
        hdr_csize      = '0;
        hdr_skybox     = '0;
        cell_ofs       = '0;
        low_byte       = '0;
        floor_word     = '0;
        cell_verdict   = ST_OK;
        first_bad_cell = ST_OK;
    endfunction

    function automatic void take_header_byte(logic [7:0] b);
        int p;
        p = int'(nbytes);
        if (p < int'(OFS_VERSION))
        begin
            if (b != MAGIC_LE[8*p +: 8])
                magic_ok = 1'b0;
        end
        else if (p < int'(OFS_FLAGS))
            hdr_version[8*(p - int'(OFS_VERSION)) +: 8] = b;
        else if (p < int'(OFS_WIDTH))
            hdr_flags[8*(p - int'(OFS_FLAGS)) +: 8] = b;
        else if (p < int'(OFS_HEIGHT))
            hdr_width[8*(p - int'(OFS_WIDTH)) +: 8] = b;
        else if (p < int'(OFS_CSIZE))
            hdr_height[8*(p - int'(OFS_HEIGHT)) +: 8] = b;
        else if (p < int'(OFS_SKYBOX))
            hdr_csize[8*(p - int'(OFS_CSIZE)) +: 8] = b;
        else
            hdr_skybox[8*(p - int'(OFS_SKYBOX)) +: 8] = b;
    endfunction

    // Cell words are judged when their upper byte arrives; the reserved word
    // closes the record and settles its verdict.
    function automatic void take_cell_byte(logic [7:0] b);
        logic [15:0] word;
        logic [2:0]  verdict;
        if (!cell_ofs[0])
            low_byte = b;
        else
        begin
            word = {b, low_byte};
            case (cell_ofs)
                CELL_FLOOR_HI:
                    floor_word = word;
                CELL_CEIL_HI:
                    cell_verdict = ($signed(floor_word) > $signed(word)) ? ST_FORMAT : ST_OK;
                CELL_FLAGS_HI:
                    if ((word & ~cell_mask) != 16'h0)
                        cell_verdict = ST_UNSUPPORTED;
                CELL_RSVD_HI:
                begin
                    verdict = (word != 16'h0) ? ST_FORMAT : cell_verdict;
                    if (first_bad_cell == ST_OK)
                        first_bad_cell = verdict;
                    cell_verdict = ST_OK;
                end
                default: ;
            endcase
        end
        cell_ofs = cell_ofs + 4'd1;
    endfunction

    function automatic logic [2:0] judge_map(output logic [31:0] cells_ok);
        logic [63:0] cells;
        logic [63:0] span;
        cells_ok = '0;
        if (nbytes < COUNT_W'(HEADER_BYTES))
            return ST_BOUNDS;
        if (!magic_ok)
            return ST_FORMAT;
        if (hdr_version != want_version)
            return ST_VERSION;
        if ((hdr_flags & ~map_mask) != 16'h0)
            return ST_UNSUPPORTED;
        if (hdr_csize == 32'h0)
            return ST_FORMAT;
        if (hdr_width == 32'h0 || hdr_height == 32'h0)
            return ST_FORMAT;
        cells = 64'(hdr_width) * 64'(hdr_height);
        if (cells > 64'hFFFF_FFFF)
            return ST_OVERFLOW;
        span = 64'(HEADER_BYTES) + cells * 64'(RECORD_BYTES);
        if (span > 64'hFFFF_FFFF)
            return ST_OVERFLOW;
        if (64'(nbytes) < span)
            return ST_BOUNDS;
        if (64'(nbytes) > span)
            return ST_FORMAT;
        if (first_bad_cell != ST_OK)
            return first_bad_cell;
        cells_ok = cells[31:0];
        return ST_OK;
    endfunction

    function automatic result_t close_map();
        result_t r;
        logic [31:0] n_cells;
        r.status      = judge_map(n_cells);
        r.map_width   = hdr_width;
        r.map_height  = hdr_height;
        r.map_flags   = hdr_flags;
        r.csize       = hdr_csize;
        r.skybox      = hdr_skybox;
        r.total_cells = n_cells;
        clear_map();
        return r;
    endfunction

    function automatic void check_field(string what, logic [31:0] want, logic [31:0] got);
        if (want !== got)
        begin
            fault_count++;
            $display("%0t: %s mismatch, expected 0x%0h, got 0x%0h", $time, what, want, got);
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        result_t want;
        if (!rst_n)
        begin
            want_version = SCHEMA_VERSION_RESET;
            map_mask     = '0;
            cell_mask    = '0;
            clear_map();
            expected_maps.delete();
        end
        else
        begin
            if (psel && penable && pwrite && pready)
            begin
                case (paddr[3:2])
                    REG_SCHEMA_VERSION:   want_version = pwdata[15:0];
                    REG_KNOWN_MAP_FLAGS:  map_mask     = pwdata[15:0];
                    REG_KNOWN_CELL_FLAGS: cell_mask    = pwdata[15:0];
                    default: ;
                endcase
            end

            if (data_valid && data_ready)
            begin
                byte_count++;
                if (nbytes < COUNT_W'(HEADER_BYTES))
                    take_header_byte(data_byte);
                else
                    take_cell_byte(data_byte);
                if (nbytes != COUNT_MAX)
                    nbytes = nbytes + 1'b1;
                if (last_byte)
                    expected_maps.push_back(close_map());
            end

            if (result_valid && result_ready)
            begin
                if (expected_maps.size() == 0)
                begin
                    fault_count++;
                    $display("%0t: unexpected result, expected none, got status %0d",
                             $time, status);
                end
                else
                begin
                    want = expected_maps.pop_front();
                    checked_count++;
                    if (want.status == ST_OK)
                        ok_count++;
                    check_field("status", 32'(want.status), 32'(status));
                    check_field("map_width", want.map_width, map_width);
                    check_field("map_height", want.map_height, map_height);
                    check_field("map_flags", 32'(want.map_flags), 32'(map_flags));
                    check_field("cell_size_out", want.csize, cell_size_out);
                    check_field("skybox_out", want.skybox, skybox_out);
                    check_field("total_cells", want.total_cells, total_cells);
                end
            end
        end
        errors       <= fault_count;
        outstanding  <= expected_maps.size();
        maps_checked <= checked_count;
        maps_ok      <= ok_count;
        bytes_seen   <= byte_count;
    end

endmodule

/* dv/tb.sv */
// Top of the map record stream validator testbench: clock, reset, register
// writes, map file requests and result back-pressure, plus the final verdict.
// Depends on mrsv_pkg, map_record_stream_validator and map_result_checker.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import mrsv_pkg::*;

    localparam int CYCLE_LIMIT  = 1_000_000;
    localparam int HOLD_CYCLES  = 400;
    localparam int DRAIN_CYCLES = 8;
    localparam int PHASE_BYTES  = 400;
    localparam int PHASE_MAPS   = 4;

    typedef enum int {
        FLAW_NONE,
        FLAW_SHORT_HEADER,
        FLAW_MAGIC,
        FLAW_VERSION,
        FLAW_MAP_FLAGS,
        FLAW_ZERO_CSIZE,
        FLAW_ZERO_DIM,
        FLAW_CELL_OVF,
        FLAW_SIZE_OVF,
        FLAW_TRUNCATED,
        FLAW_EXTRA
    } map_flaw_e;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [3:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        data_valid = 1'b0;
    logic        data_ready;
    logic [7:0]  data_byte = '0;
    logic        last_byte = 1'b0;
    logic        result_valid;
    logic        result_ready = 1'b0;
    logic [2:0]  status;
    logic [31:0] map_width;
    logic [31:0] map_height;
    logic [15:0] map_flags;
    logic [31:0] cell_size_out;
    logic [31:0] skybox_out;
    logic [31:0] total_cells;

    int errors;
    int outstanding;
    int maps_checked;
    int maps_ok;
    int bytes_seen;

    logic        idle_en = 1'b1;
    logic        hold_req = 1'b0;
    logic [15:0] cfg_version = SCHEMA_VERSION_RESET;
    logic [15:0] cfg_map_flags = '0;
    logic [15:0] cfg_cell_flags = '0;
    logic [7:0]  map_q[$];
    int          sent_bytes = 0;
    int          sent_maps = 0;
    int          cycle_count = 0;

    map_record_stream_validator u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .data_valid   (data_valid),
        .data_ready   (data_ready),
        .data_byte    (data_byte),
        .last_byte    (last_byte),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .status       (status),
        .map_width    (map_width),
        .map_height   (map_height),
        .map_flags    (map_flags),
        .cell_size_out(cell_size_out),
        .skybox_out   (skybox_out),
        .total_cells  (total_cells)
    );

    map_result_checker u_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .pready       (pready),
        .data_valid   (data_valid),
        .data_ready   (data_ready),
        .data_byte    (data_byte),
        .last_byte    (last_byte),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .status       (status),
        .map_width    (map_width),
        .map_height   (map_height),
        .map_flags    (map_flags),
        .cell_size_out(cell_size_out),
        .skybox_out   (skybox_out),
        .total_cells  (total_cells),
        .errors       (errors),
        .outstanding  (outstanding),
        .maps_checked (maps_checked),
        .maps_ok      (maps_ok),
        .bytes_seen   (bytes_seen)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("Timed out after %0d cycles with %0d results still owed",
                 cycle_count, outstanding);
        $display("*** FAILED ***");
        $finish;
    end

    // Mostly no gap, some short gaps and now and then a long one.
    function automatic int gap_cycles();
        int r;
        r = $urandom_range(99);
        if (r < 70)
            return 0;
        if (r < 95)
            return $urandom_range(3, 1);
        return $urandom_range(40, 10);
    endfunction

    // Result back-pressure, with one long hold-off that fills the block up.
    initial
    begin
        int stall;
        bit held;
        held = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (hold_req && !held)
            begin
                held = 1'b1;
                result_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            else
            begin
                stall = idle_en ? gap_cycles() : 0;
                if (stall == 0)
                    result_ready <= 1'b1;
                else
                begin
                    result_ready <= 1'b0;
                    repeat (stall - 1) @(posedge clk);
                end
            end
        end
    end

    task automatic reg_write(input logic [1:0] idx, input logic [15:0] value);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= {16'($urandom), value};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready) @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic apply_settings(input logic [15:0] ver, input logic [15:0] map_mask,
                                  input logic [15:0] cell_mask);
        reg_write(REG_SCHEMA_VERSION, ver);
        reg_write(REG_KNOWN_MAP_FLAGS, map_mask);
        reg_write(REG_KNOWN_CELL_FLAGS, cell_mask);
        cfg_version    = ver;
        cfg_map_flags  = map_mask;
        cfg_cell_flags = cell_mask;
    endtask

    // Returns at the edge that accepts the request; the caller either offers
    // the next one or drops valid in that same step.
    task automatic send_byte(input logic [7:0] b, input logic fin);
        int gap;
        gap = idle_en ? gap_cycles() : 0;
        if (gap > 0)
        begin
            data_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        data_valid <= 1'b1;
        data_byte  <= b;
        last_byte  <= fin;
        @(posedge clk);
        while (!data_ready) @(posedge clk);
        sent_bytes++;
    endtask

    task automatic send_map();
        foreach (map_q[i])
            send_byte(map_q[i], i == map_q.size() - 1);
        map_q.delete();
        sent_maps++;
    endtask

    task automatic drain();
        data_valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    function automatic void put_word(logic [31:0] v, int n);
        for (int i = 0; i < n; i++)
            map_q.push_back(v[8*i +: 8]);
    endfunction

    function automatic void put_header(logic [15:0] ver, logic [15:0] flags,
                                       logic [31:0] w, logic [31:0] h,
                                       logic [31:0] cs, logic [31:0] sky);
        put_word(32'h3150_414D, 4);
        put_word(32'(ver), 2);
        put_word(32'(flags), 2);
        put_word(w, 4);
        put_word(h, 4);
        put_word(cs, 4);
        put_word(sky, 4);
    endfunction

    function automatic void put_cell(logic [15:0] fl, logic [15:0] ce,
                                     logic [15:0] cf, logic [15:0] rsv);
        put_word(32'(fl), 2);
        put_word(32'(ce), 2);
        put_word($urandom, 4);
        put_word($urandom, 4);
        put_word(32'(cf), 2);
        put_word(32'(rsv), 2);
    endfunction

    // Mostly sound cells; the rest are fully random and often fail.
    function automatic void put_cells(int n);
        logic [15:0] a;
        logic [15:0] b;
        logic [15:0] t;
        for (int i = 0; i < n; i++)
        begin
            a = 16'($urandom);
            b = 16'($urandom);
            if ($urandom_range(99) < 12)
                put_cell(a, b, 16'($urandom), ($urandom_range(1) != 0) ? 16'($urandom) : 16'h0);
            else
            begin
                if ($urandom_range(19) == 0)
                    b = a;
                if ($signed(a) > $signed(b))
                begin
                    t = a;
                    a = b;
                    b = t;
                end
                put_cell(a, b, 16'($urandom) & cfg_cell_flags, 16'h0);
            end
        end
    endfunction

    function automatic void build_random_map();
        map_flaw_e   flaw;
        int          ncell;
        int          cut;
        logic [31:0] w;
        logic [31:0] h;
        logic [31:0] cs;
        logic [31:0] sky;
        logic [15:0] ver;
        logic [15:0] fl;
        logic [15:0] extra;
        if ($urandom_range(99) < 50)
            flaw = FLAW_NONE;
        else
            flaw = map_flaw_e'($urandom_range(FLAW_EXTRA, FLAW_SHORT_HEADER));
        w = $urandom_range(3, 1);
        h = $urandom_range(3, 1);
        if ($urandom_range(15) == 0)
            w = $urandom_range(8, 4);
        cs = ($urandom_range(1) != 0) ? $urandom : $urandom_range(64, 1);
        if (cs == 32'h0)
            cs = 32'h1;
        sky = $urandom;
        ver = cfg_version;
        fl = 16'($urandom) & cfg_map_flags;
        ncell = int'(w * h);
        case (flaw)
            FLAW_VERSION:
                ver = ver ^ 16'($urandom_range(16'hFFFF, 1));
            FLAW_MAP_FLAGS:
            begin
                extra = 16'($urandom) & ~cfg_map_flags;
                fl = fl | ((extra != 16'h0) ? extra : ~cfg_map_flags);
            end
            FLAW_ZERO_CSIZE:
                cs = 32'h0;
            FLAW_ZERO_DIM:
            begin
                if ($urandom_range(1) != 0)
                    w = 32'h0;
                else
                    h = 32'h0;
                ncell = $urandom_range(2);
            end
            FLAW_CELL_OVF:
            begin
                w = $urandom | 32'h0001_0000;
                h = $urandom | 32'h0001_0000;
                ncell = 0;
            end
            FLAW_SIZE_OVF:
            begin
                w = 32'h1;
                h = $urandom_range(32'hFFFF_FFFF, 32'h0FFF_FFFF);
                if ($urandom_range(1) != 0)
                begin
                    w = h;
                    h = 32'h1;
                end
                ncell = 0;
            end
            default: ;
        endcase
        put_header(ver, fl, w, h, cs, sky);
        if (flaw == FLAW_MAGIC)
            map_q[$urandom_range(3)] ^= 8'($urandom_range(255, 1));
        put_cells(ncell);
        if (flaw == FLAW_TRUNCATED)
        begin
            cut = $urandom_range(16 * ncell, 1);
            repeat (cut) void'(map_q.pop_back());
        end
        if (flaw == FLAW_EXTRA || (ncell == 0 && $urandom_range(1) != 0))
            repeat ($urandom_range(20, 1)) map_q.push_back(8'($urandom));
        if (flaw == FLAW_SHORT_HEADER)
        begin
            cut = $urandom_range(HEADER_BYTES - 1, 1);
            while (map_q.size() > cut)
                void'(map_q.pop_back());
            if ($urandom_range(1) != 0)
                foreach (map_q[i])
                    map_q[i] = 8'($urandom);
        end
    endfunction

    // Runs under the reset-like setting: version 1, no known flags.
    task automatic run_directed();
        // A lone byte, then a header one byte short.
        map_q.push_back(8'hFF);
        send_map();
        put_header(cfg_version, 16'h0, '1, '1, '1, '1);
        void'(map_q.pop_back());
        send_map();
        // Signed extremes: lowest floor under highest ceiling passes.
        put_header(cfg_version, 16'h0, 32'd1, 32'd1, '1, '1);
        put_cell(16'h8000, 16'h7FFF, 16'h0, 16'h0);
        send_map();
        put_header(cfg_version, 16'h0, 32'd1, 32'd2, 32'd1, 32'd0);
        put_cell(16'h7FFF, 16'h8000, 16'h0, 16'h0);
        put_cell(16'h1234, 16'h1234, 16'h0, 16'h0);
        send_map();
        // A nonzero reserved word outranks an unknown flag, which in turn
        // outranks a floor above the ceiling.
        put_header(cfg_version, 16'h0, 32'd2, 32'd1, 32'd5, 32'd0);
        put_cell(16'h0, 16'h0, 16'h0, 16'h0);
        put_cell(16'h0005, 16'h0005, 16'h8000, 16'h0001);
        send_map();
        put_header(cfg_version, 16'h0, 32'd1, 32'd1, 32'd5, 32'd0);
        put_cell(16'h0001, 16'h0000, 16'h0001, 16'h0);
        send_map();
        // Cell count beyond 32 bits, then file size just over and just within.
        put_header(cfg_version, 16'h0, '1, '1, 32'd1, 32'd1);
        send_map();
        put_header(cfg_version, 16'h0, 32'd1, 32'h0FFF_FFFF, 32'd1, 32'd1);
        send_map();
        put_header(cfg_version, 16'h0, 32'h0FFF_FFFE, 32'd1, 32'd1, 32'd1);
        send_map();
        // A trailing byte makes the file long, which hides the bad cell.
        put_header(cfg_version, 16'h0, 32'd1, 32'd1, 32'd1, 32'd1);
        put_cell(16'h0, 16'h0, 16'h0001, 16'h0);
        map_q.push_back(8'h00);
        send_map();
    endtask

    initial
    begin
        int b0;
        int m0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        for (int ph = 0; ph < 4; ph++)
        begin
            idle_en <= (ph != 1);
            case (ph)
                0: apply_settings(16'h0001, 16'h0000, 16'h0000);
                1: apply_settings(16'hFFFF, 16'hFFFF, 16'hFFFF);
                2: apply_settings(16'h0000, 16'($urandom), 16'($urandom));
                default: apply_settings(16'($urandom), 16'($urandom), 16'($urandom));
            endcase
            if (ph == 0)
                run_directed();
            if (ph == 2)
                hold_req <= 1'b1;
            b0 = sent_bytes;
            m0 = sent_maps;
            while (sent_bytes - b0 < PHASE_BYTES || sent_maps - m0 < PHASE_MAPS)
            begin
                build_random_map();
                send_map();
            end
            drain();
        end
        $display("Sent %0d bytes in %0d map files over four register settings;",
                 sent_bytes, sent_maps);
        $display("checked %0d results, %0d of them clean, with gaps and one long stall.",
                 maps_checked, maps_ok);
        if (errors == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
